// File: rtl/core/ufd_pkg.sv
// ----------------------------------------------------------------------------
// UART frame deframer package
// Shared constants, status codes and the result item type.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  localparam logic [ByteW-1:0] SofFirst    = 8'h55;
  localparam logic [ByteW-1:0] SofSecond   = 8'hAA;
  localparam logic [LenW-1:0]  MaxLenReset = 16'd540;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] command;
    logic             is_end;
    status_e          status;
    logic [LenW-1:0]  payload_length;
  } result_t;

endpackage

// File: rtl/core/ufd_parser.sv
// ----------------------------------------------------------------------------
// UART frame deframer - frame parser
// Frame state machine; one byte per step, at most one result item per step.
// ----------------------------------------------------------------------------
module ufd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [ufd_pkg::ByteW-1:0] byte_i,
  input  logic [ufd_pkg::LenW-1:0]  max_len_i,
  output logic                      res_vld_o,
  output ufd_pkg::result_t          res_o
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_VERSION = 3'd2,
    PH_CMD     = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_LEN_LO  = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_CHECK   = 3'd7
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [ufd_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [ufd_pkg::LenW-1:0]  len_q, len_d;
  logic [ufd_pkg::LenW-1:0]  left_q, left_d;
  logic [ufd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [ufd_pkg::ByteW-1:0] sum_add;
  logic [ufd_pkg::LenW-1:0]  full_len;
  logic [ufd_pkg::LenW-1:0]  left_dec;

  assign sum_add  = sum_q + byte_i;
  assign full_len = {len_q[ufd_pkg::LenW-1:ufd_pkg::ByteW], byte_i};
  assign left_dec = left_q - ufd_pkg::LenW'(1);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    left_d    = left_q;
    sum_d     = sum_q;
    res_vld_o = 1'b0;
    res_o.out_byte       = '0;
    res_o.command        = cmd_q;
    res_o.is_end         = 1'b1;
    res_o.status         = ufd_pkg::ST_GOOD;
    res_o.payload_length = len_q;
    unique case (phase_q)
      PH_HUNT1: begin
        if (byte_i == ufd_pkg::SofFirst) begin
          sum_d   = byte_i;
          phase_d = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (byte_i == ufd_pkg::SofSecond) begin
          sum_d   = sum_add;
          phase_d = PH_VERSION;
        end else if (byte_i == ufd_pkg::SofFirst) begin
          sum_d = byte_i;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_VERSION: begin
        sum_d   = sum_add;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        sum_d   = sum_add;
        cmd_d   = byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_d   = sum_add;
        len_d   = {byte_i, len_q[ufd_pkg::ByteW-1:0] & '0};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_d = sum_add;
        len_d = full_len;
        if (full_len >= max_len_i) begin
          res_vld_o            = 1'b1;
          res_o.status         = ufd_pkg::ST_TOO_LONG;
          res_o.payload_length = full_len;
          phase_d              = PH_HUNT1;
        end else begin
          left_d  = full_len;
          phase_d = (full_len == '0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d          = sum_add;
        res_vld_o      = 1'b1;
        res_o.out_byte = byte_i;
        res_o.is_end   = 1'b0;
        left_d         = left_dec;
        if (left_dec == '0) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        res_vld_o    = 1'b1;
        res_o.status = (byte_i == sum_q) ? ufd_pkg::ST_GOOD : ufd_pkg::ST_BAD_SUM;
        phase_d      = PH_HUNT1;
      end
      default: phase_d = PH_HUNT1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      cmd_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
    end
  end

`ifndef SYNTH
  // results only come from the length, payload and checksum phases
  a_res_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> (phase_q == PH_LEN_LO || phase_q == PH_PAYLOAD || phase_q == PH_CHECK))
    else $error("result from a non-emitting phase");
  // payload phase never runs with nothing left
  a_left_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with zero bytes left");
  // checksum byte always ends the frame
  a_check_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHECK |=> phase_q == PH_HUNT1)
    else $error("no return to hunting after checksum");
`endif

endmodule

// File: rtl/core/ufd_out_reg.sv
// ----------------------------------------------------------------------------
// UART frame deframer - result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module ufd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_vld_i,
  input  ufd_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             ready_o,
  output logic             out_valid_o,
  output ufd_pkg::result_t res_o
);

  logic             vld_q, vld_d;
  ufd_pkg::result_t res_q;

  assign ready_o = !vld_q || !out_stall_i;
  assign vld_d   = ready_o ? (load_i && res_vld_i) : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/uart_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// UART frame deframer
// Parses 55 AA / version / command / length / payload / checksum frames.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register; the parser's result
//   item for it is then registered in the result register for the sink.
// Throughput: one byte per cycle when rx_stall_o is low; the input and result
//   registers let a byte be taken while a finished item still waits downstream.
// Reset: rst_ni (async, active low) empties both registers, returns the
//   parser to hunting and sets the length limit to 540.
module uart_frame_deframer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: length limit
  input  logic                      cfg_we_i,
  input  logic [ufd_pkg::LenW-1:0]  cfg_data_i,
  // byte stream in
  input  logic                      rx_valid_i,
  output logic                      rx_stall_o,
  input  logic [ufd_pkg::ByteW-1:0] rx_byte_i,
  // result items out
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ufd_pkg::ByteW-1:0] out_byte_o,
  output logic [ufd_pkg::ByteW-1:0] command_o,
  output logic                      is_end_o,
  output logic [1:0]                status_o,
  output logic [ufd_pkg::LenW-1:0]  payload_length_o
);

  logic                      in_vld_q, in_vld_d;
  logic [ufd_pkg::ByteW-1:0] in_byte_q;
  logic [ufd_pkg::LenW-1:0]  max_len_q;
  logic                      accept;
  logic                      advance;
  logic                      out_ready;
  logic                      res_vld;
  ufd_pkg::result_t          res;
  ufd_pkg::result_t          out_res;

  // Input register moves on whenever the result register can take its item.
  assign advance    = in_vld_q && out_ready;
  assign rx_stall_o = in_vld_q && !out_ready;
  assign accept     = rx_valid_i && !rx_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      max_len_q <= ufd_pkg::MaxLenReset;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_we_i) max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= rx_byte_i;
  end

  ufd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ufd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign out_byte_o       = out_res.out_byte;
  assign command_o        = out_res.command;
  assign is_end_o         = out_res.is_end;
  assign status_o         = out_res.status;
  assign payload_length_o = out_res.payload_length;

endmodule
